[design/khs_pkg.sv]
// khs_pkg: shared types, widths and constants for the key/hammer strike model.
// No dependencies; every other file in design/ depends on this package.
`timescale 1ns / 1ps

package khs_pkg;

    // Field widths
    localparam int KEY_W   = 16;
    localparam int DT_W    = 20;
    localparam int VEL_W   = 32;
    localparam int GRAV_W  = 24;
    localparam int TRAVEL_W = 15;
    localparam int LEVEL_W = 16;
    localparam int GAIN_W  = 16;
    localparam int CFG_W   = 24;
    localparam int CFG_IDX_W = 2;

    // Shared multiplier and divider widths
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 20;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int DVD_W   = 38;
    localparam int REM_W   = 21;
    localparam int PAIR_W  = 5;

    // Wide hammer position before the lift and travel clamps
    localparam int P_W     = 36;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRAVEL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 2'd3;

    // Reset values
    localparam logic [GRAV_W-1:0]   GRAVITY_RST = 24'd2510502;
    localparam logic [TRAVEL_W-1:0] TRAVEL_RST  = 15'd2560;
    localparam logic [LEVEL_W-1:0]  LEVEL_RST   = 16'd1331;
    localparam logic [GAIN_W-1:0]   GAIN_RST    = 16'd18022;

    // Arithmetic constants
    localparam logic [DT_W-1:0]  US_PER_S    = 20'd1000000;
    localparam logic [REM_W-1:0] TWO_US_PER_S = 21'd2000000;
    localparam logic [VEL_W-1:0] VEL_MAX     = 32'h7FFF_FFFF;
    localparam logic [VEL_W-1:0] VEL_MIN     = 32'h8000_0000;

    typedef struct packed {
        logic [KEY_W-1:0] key_position;
        logic [DT_W-1:0]  elapsed_us;
    } key_item_t;

    typedef struct packed {
        logic [KEY_W-1:0] hammer_position;
        logic [VEL_W-1:0] hammer_speed;
        logic [VEL_W-1:0] key_speed;
        logic             hammer_striking;
        logic             key_striking;
    } hammer_item_t;

    // Divider command from the sequencer
    typedef struct packed {
        logic              start;
        logic [PAIR_W-1:0] pairs;
    } div_cmd_t;

endpackage

[design/khs_if.sv]
// khs_if: valid/ready channel interfaces for key samples and hammer results.
// Depends on khs_pkg for the payload types.
`timescale 1ns / 1ps

interface khs_key_if;
    logic                  valid;
    logic                  ready;
    khs_pkg::key_item_t    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface khs_hammer_if;
    logic                  valid;
    logic                  ready;
    khs_pkg::hammer_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/khs_mul.sv]
// khs_mul: shared unsigned multiplier with a registered product.
// Depends on khs_pkg for operand widths.
`timescale 1ns / 1ps

module khs_mul (
    input  logic                         clk,
    input  logic [khs_pkg::MUL_A_W-1:0]  a,
    input  logic [khs_pkg::MUL_B_W-1:0]  b,
    output logic [khs_pkg::PROD_W-1:0]   prod
);
    import khs_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

[design/khs_div.sv]
// khs_div: shared restoring divider, two quotient bits per cycle.
// Depends on khs_pkg. Caller pre-aligns the dividend and the starting remainder.
`timescale 1ns / 1ps

module khs_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  khs_pkg::div_cmd_t           cmd,
    input  logic [khs_pkg::REM_W-1:0]   rem_init,
    input  logic [khs_pkg::DVD_W-1:0]   dividend,
    input  logic [khs_pkg::REM_W-1:0]   divisor,
    output logic [khs_pkg::DVD_W-1:0]   quotient,
    output logic                        done
);
    import khs_pkg::*;

    logic [REM_W-1:0]  rem_reg;
    logic [DVD_W-1:0]  dq_reg;      // dividend bits shift out the top, quotient in the bottom
    logic [REM_W-1:0]  divisor_reg;
    logic [PAIR_W-1:0] cnt_reg;
    logic              run_reg;
    logic              done_reg;

    logic [REM_W-1:0]  rem_next;
    logic [DVD_W-1:0]  dq_next;

    always_comb
    begin
        logic [REM_W:0] trial;
        logic           ge;
        rem_next = rem_reg;
        dq_next  = dq_reg;
        for (int k = 0; k < 2; k++)
        begin
            trial = {rem_next, dq_next[DVD_W-1]};
            ge    = (trial >= {1'b0, divisor_reg});
            if (ge)
            begin
                trial = trial - {1'b0, divisor_reg};
            end
            rem_next = trial[REM_W-1:0];
            dq_next  = {dq_next[DVD_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                cnt_reg <= cmd.pairs;
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == PAIR_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            rem_reg     <= rem_init;
            dq_reg      <= dividend;
            divisor_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
        end
    end

    assign quotient = dq_reg;
    assign done     = done_reg;

endmodule

[design/key_hammer_strike_model.sv]
// key_hammer_strike_model: top level, sequencer around a shared multiplier and divider.
// Depends on khs_pkg, khs_if, khs_mul and khs_div.
`timescale 1ns / 1ps
//
//  channel       dir   handshake      payload
//  key_sample    sink  valid/ready    key_position (s16), elapsed_us (u20)
//  hammer_state  src   valid/ready    hammer_position, hammer_speed, key_speed,
//                                     hammer_striking, key_striking
//  cfg_*         in    cfg_write      cfg_index (2b), cfg_data (24b), no read-back
//
//  One transfer in yields one transfer out. The shared divider runs three divisions
//  in turn (key speed, gravity step, trapezoid step), each after its multiplier
//  steps, and the final write-back follows; the next transfer in is taken only once
//  the sequencer is back in idle, so items are not overlapped.
//  key_sample.ready is high only while the sequencer is idle; a result waiting in the
//  output register does not block the next transfer in, only the final write-back.
//  Reset clears the hammer state, the last key position and loads register defaults.

module key_hammer_strike_model (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [khs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [khs_pkg::CFG_W-1:0]       cfg_data,
    khs_key_if.sink                         key_sample,
    khs_hammer_if.source                    hammer_state
);
    import khs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_K_MUL1,
        ST_K_MUL2,
        ST_K_DIV_GO,
        ST_K_DIV_WAIT,
        ST_G_MUL,
        ST_G_DIV_GO,
        ST_G_DIV_WAIT,
        ST_T_MUL,
        ST_T_DIV_GO,
        ST_T_DIV_WAIT,
        ST_FINISH
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic [GRAV_W-1:0]   gravity_reg;
    logic [TRAVEL_W-1:0] travel_reg;
    logic [LEVEL_W-1:0]  level_reg;
    logic [GAIN_W-1:0]   gain_reg;

    // Model state
    logic [KEY_W-1:0] last_key_reg;
    logic [KEY_W-1:0] hpos_reg;
    logic [VEL_W-1:0] hvel_reg;

    // Per-item working registers
    logic [KEY_W-1:0] key_reg;
    logic [DT_W-1:0]  dt_reg;
    logic [VEL_W-1:0] kspeed_reg;
    logic [VEL_W-1:0] v1_reg;

    // Output register
    hammer_item_t out_reg;
    logic         out_valid_reg;

    // Shared units
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod;
    div_cmd_t           div_cmd;
    logic [REM_W-1:0]   div_rem;
    logic [DVD_W-1:0]   div_dvd;
    logic [REM_W-1:0]   div_divisor;
    logic [DVD_W-1:0]   quot;
    logic               div_done;

    khs_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    khs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd),
        .rem_init (div_rem),
        .dividend (div_dvd),
        .divisor  (div_divisor),
        .quotient (quot),
        .done     (div_done)
    );

    // Key position difference; magnitude always fits 16 bits
    logic [KEY_W:0]   diff;
    logic             diff_neg;
    logic [KEY_W:0]   diff_abs;
    logic [KEY_W-1:0] diff_mag;

    assign diff     = {key_reg[KEY_W-1], key_reg} - {last_key_reg[KEY_W-1], last_key_reg};
    assign diff_neg = diff[KEY_W];
    assign diff_abs = diff_neg ? (~diff + 1'b1) : diff;
    assign diff_mag = diff_abs[KEY_W-1:0];

    // Velocity sum for the trapezoid step
    logic [VEL_W:0] vsum;
    logic           vsum_neg;
    logic [VEL_W:0] vsum_mag;

    assign vsum     = {hvel_reg[VEL_W-1], hvel_reg} + {v1_reg[VEL_W-1], v1_reg};
    assign vsum_neg = vsum[VEL_W];
    assign vsum_mag = vsum_neg ? (~vsum + 1'b1) : vsum;

    // Operand selection for the shared units
    always_comb
    begin
        mul_a       = '0;
        mul_b       = '0;
        div_cmd     = '0;
        div_rem     = '0;
        div_dvd     = '0;
        div_divisor = '0;
        case (state_reg)
            ST_K_MUL1:
            begin
                mul_a = MUL_A_W'(gain_reg);
                mul_b = MUL_B_W'(diff_mag);
            end
            ST_K_MUL2:
            begin
                mul_a = MUL_A_W'(prod[VEL_W-1:0]);
                mul_b = US_PER_S;
            end
            ST_K_DIV_GO:
            begin
                // gain*|diff|*1e6 / 16384, then divide by dt
                div_cmd.start = 1'b1;
                div_cmd.pairs = PAIR_W'(19);
                div_dvd       = prod[51:14];
                div_divisor   = REM_W'(dt_reg);
            end
            ST_G_MUL:
            begin
                mul_a = MUL_A_W'(gravity_reg);
                mul_b = dt_reg;
            end
            ST_G_DIV_GO:
            begin
                // product < 2^44, quotient < 2^26
                div_cmd.start = 1'b1;
                div_cmd.pairs = PAIR_W'(13);
                div_rem       = REM_W'(prod[43:26]);
                div_dvd       = {prod[25:0], 12'b0};
                div_divisor   = REM_W'(US_PER_S);
            end
            ST_T_MUL:
            begin
                mul_a = MUL_A_W'(vsum_mag);
                mul_b = dt_reg;
            end
            ST_T_DIV_GO:
            begin
                // product < 2^53, quotient < 2^34
                div_cmd.start = 1'b1;
                div_cmd.pairs = PAIR_W'(17);
                div_rem       = REM_W'(prod[52:34]);
                div_dvd       = {prod[33:0], 4'b0};
                div_divisor   = TWO_US_PER_S;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // Key speed from the quotient, signed and saturated
    logic [VEL_W-1:0] kspeed_calc;

    always_comb
    begin
        if (dt_reg == '0)
        begin
            kspeed_calc = '0;
        end
        else if (!diff_neg)
        begin
            kspeed_calc = (quot > DVD_W'(VEL_MAX)) ? VEL_MAX : quot[VEL_W-1:0];
        end
        else
        begin
            kspeed_calc = (quot > DVD_W'(VEL_MIN)) ? VEL_MIN : (~quot[VEL_W-1:0] + 1'b1);
        end
    end

    // Gravity step: v1 = sat(v0 - dv), only low side can overflow
    logic [VEL_W:0]   vdrop;
    logic [VEL_W-1:0] v1_calc;

    assign vdrop   = {hvel_reg[VEL_W-1], hvel_reg} - (VEL_W+1)'(quot[25:0]);
    assign v1_calc = (vdrop[VEL_W] != vdrop[VEL_W-1]) ? VEL_MIN : vdrop[VEL_W-1:0];

    // Final position: trapezoid add kept wide, then key lift and travel limit
    logic [P_W-1:0]   hpos_ext;
    logic [P_W-1:0]   tstep;
    logic [P_W-1:0]   p_raw;
    logic [P_W-1:0]   key_ext;
    logic             lift;
    logic [P_W-1:0]   p_lift;
    logic [VEL_W-1:0] v_lift;
    logic             hstrike;
    logic             kstrike;
    logic [KEY_W-1:0] p_fin;
    logic [VEL_W-1:0] v_fin;

    assign hpos_ext = {{(P_W-KEY_W){hpos_reg[KEY_W-1]}}, hpos_reg};
    assign tstep    = P_W'(quot[33:0]);
    assign p_raw    = vsum_neg ? (hpos_ext - tstep) : (hpos_ext + tstep);
    assign key_ext  = {{(P_W-KEY_W){key_reg[KEY_W-1]}}, key_reg};
    assign lift     = $signed(p_raw) < $signed(key_ext);
    assign p_lift   = lift ? key_ext : p_raw;
    assign v_lift   = (lift && ($signed(v1_reg) < $signed(kspeed_reg))) ? kspeed_reg : v1_reg;
    assign hstrike  = $signed(p_lift) > $signed(P_W'(travel_reg));
    assign kstrike  = $signed(key_reg) < $signed(level_reg);

    always_comb
    begin
        if (hstrike)
        begin
            p_fin = KEY_W'(travel_reg);
            v_fin = (v_lift == VEL_MIN) ? VEL_MAX : (~v_lift + 1'b1);
        end
        else
        begin
            p_fin = p_lift[KEY_W-1:0];
            v_fin = v_lift;
        end
    end

    logic in_xfer;
    logic out_free;

    assign in_xfer  = key_sample.valid && key_sample.ready;
    assign out_free = !out_valid_reg || hammer_state.ready;

    // Sequencer, state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gravity_reg   <= GRAVITY_RST;
            travel_reg    <= TRAVEL_RST;
            level_reg     <= LEVEL_RST;
            gain_reg      <= GAIN_RST;
            last_key_reg  <= '0;
            hpos_reg      <= '0;
            hvel_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_GRAVITY: gravity_reg <= cfg_data[GRAV_W-1:0];
                    REG_TRAVEL:  travel_reg  <= cfg_data[TRAVEL_W-1:0];
                    REG_LEVEL:   level_reg   <= cfg_data[LEVEL_W-1:0];
                    REG_GAIN:    gain_reg    <= cfg_data[GAIN_W-1:0];
                    default:     gain_reg    <= gain_reg;
                endcase
            end

            // in ST_FINISH a draining output is refilled by the write-back below
            if (out_valid_reg && hammer_state.ready && state_reg != ST_FINISH)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        state_reg <= ST_K_MUL1;
                    end
                end
                ST_K_MUL1:   state_reg <= ST_K_MUL2;
                ST_K_MUL2:   state_reg <= ST_K_DIV_GO;
                ST_K_DIV_GO: state_reg <= ST_K_DIV_WAIT;
                ST_K_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_G_MUL;
                    end
                end
                ST_G_MUL:    state_reg <= ST_G_DIV_GO;
                ST_G_DIV_GO: state_reg <= ST_G_DIV_WAIT;
                ST_G_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_T_MUL;
                    end
                end
                ST_T_MUL:    state_reg <= ST_T_DIV_GO;
                ST_T_DIV_GO: state_reg <= ST_T_DIV_WAIT;
                ST_T_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        last_key_reg  <= key_reg;
                        hpos_reg      <= p_fin;
                        hvel_reg      <= v_fin;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Item payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            key_reg <= key_sample.data.key_position;
            dt_reg  <= key_sample.data.elapsed_us;
        end
        if (state_reg == ST_K_DIV_WAIT && div_done)
        begin
            kspeed_reg <= kspeed_calc;
        end
        if (state_reg == ST_G_DIV_WAIT && div_done)
        begin
            v1_reg <= v1_calc;
        end
        if (state_reg == ST_FINISH && out_free)
        begin
            out_reg.hammer_position <= p_fin;
            out_reg.hammer_speed    <= v_fin;
            out_reg.key_speed       <= kspeed_reg;
            out_reg.hammer_striking <= hstrike;
            out_reg.key_striking    <= kstrike;
        end
    end

    assign key_sample.ready   = (state_reg == ST_IDLE);
    assign hammer_state.valid = out_valid_reg;
    assign hammer_state.data  = out_reg;

endmodule
